// File: sv/lgpc_pkg.sv
// ---------------------------------------------------------------------------
// lgpc_pkg
// Shared types and constants of the linear gradient pixel color pipeline.
// ---------------------------------------------------------------------------
package lgpc_pkg;

  localparam int COEF_W    = 26;   // signed Q1.24 coefficients
  localparam int POS_W     = 17;   // Q1.16 position, 1.0 fits
  localparam int STOP_W    = 49;   // position plus RGBA
  localparam int STOP_REGS = 4;
  localparam int CHANS     = 4;    // red, green, blue, alpha
  localparam int DIV_BITS  = 8;    // quotient bits, result never above 255
  localparam int NUM_W     = 25;   // 255 * gap fits here
  localparam int CFG_IDX_W = 3;
  localparam logic [POS_W-1:0] T_ONE = 17'h10000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_X   = 3'd0,
    REG_COEF_Y   = 3'd1,
    REG_STOPS    = 3'd2,
    REG_STOP_0   = 3'd3,
    REG_STOP_1   = 3'd4,
    REG_STOP_2   = 3'd5,
    REG_STOP_3   = 3'd6
  } cfg_reg_t;

  typedef logic [CHANS-1:0][7:0]          chan_t;      // [0] is red
  typedef logic [STOP_REGS-1:0][STOP_W-1:0] stop_bank_t;

  // selected stop pair, handed to the interpolation stages
  typedef struct packed {
    logic [POS_W-1:0] gap;
    logic [POS_W-1:0] delta;
    chan_t            col_a;
    chan_t            col_b;
  } sel_t;

  function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] w);
    return w[STOP_W-1:32];
  endfunction

  function automatic chan_t stop_col(input logic [STOP_W-1:0] w);
    chan_t c;
    c[0] = w[31:24];
    c[1] = w[23:16];
    c[2] = w[15:8];
    c[3] = w[7:0];
    return c;
  endfunction

endpackage

// File: sv/lgpc_coord.sv
// ---------------------------------------------------------------------------
// lgpc_coord
// Two stages: coefficient products, then sum and clamp of t to [0, 1] Q1.16.
// ---------------------------------------------------------------------------
module lgpc_coord #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         in_vld,
  input  logic [COORD_BITS-1:0]        off_x,
  input  logic [COORD_BITS-1:0]        off_y,
  input  logic signed [lgpc_pkg::COEF_W-1:0] coef_x,
  input  logic signed [lgpc_pkg::COEF_W-1:0] coef_y,
  output logic                         t_vld,
  output logic [lgpc_pkg::POS_W-1:0]   t_val
);
  import lgpc_pkg::*;

  localparam int P_W = COORD_BITS + 1 + COEF_W;
  localparam int S_W = P_W + 1;
  localparam int Q_W = S_W - 8;

  logic                  p_vld_r;
  logic signed [P_W-1:0] px_r, py_r;
  logic signed [S_W-1:0] sum;
  logic [Q_W-1:0]        quo;
  logic [POS_W-1:0]      t_nxt;
  logic                  t_vld_r;
  logic [POS_W-1:0]      t_r;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (advance) begin
      p_vld_r <= in_vld;
    end
    if (advance) begin
      px_r <= P_W'($signed({1'b0, off_x}) * coef_x);
      py_r <= P_W'($signed({1'b0, off_y}) * coef_y);
    end
  end

  // stage 2: sum, drop 8 fraction bits, clamp
  always_comb begin
    sum = S_W'(px_r) + S_W'(py_r);
    quo = Q_W'(sum >>> 8);
    if (sum <= 0) begin
      t_nxt = '0;
    end else if (quo > Q_W'(T_ONE)) begin
      t_nxt = T_ONE;
    end else begin
      t_nxt = quo[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (advance) begin
      t_vld_r <= p_vld_r;
    end
    if (advance) begin
      t_r <= t_nxt;
    end
  end

  assign t_vld = t_vld_r;
  assign t_val = t_r;

endmodule

// File: sv/lgpc_stop_sel.sv
// ---------------------------------------------------------------------------
// lgpc_stop_sel
// Three stages: stop pair search, channel products, numerator sum.
// ---------------------------------------------------------------------------
module lgpc_stop_sel #(
  parameter int MAX_STOPS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         t_vld,
  input  logic [lgpc_pkg::POS_W-1:0]   t_val,
  input  logic [2:0]                   stops_in_use,
  input  lgpc_pkg::stop_bank_t         stops,
  output logic                         num_vld,
  output logic [lgpc_pkg::CHANS-1:0][lgpc_pkg::NUM_W-1:0] num,
  output logic [lgpc_pkg::POS_W-1:0]   divisor,
  output lgpc_pkg::sel_t               sel_dbg
);
  import lgpc_pkg::*;

  localparam int LIM   = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;
  localparam int PAIRS = LIM - 1;

  logic [3:0] n_eff;
  sel_t       sel_nxt;
  logic       sel_vld_r;
  sel_t       sel_r;
  logic       prd_vld_r;
  logic [CHANS-1:0][NUM_W-1:0] pa_r, pb_r;
  logic [POS_W-1:0]            pgap_r;
  chan_t                       pcol_r;
  logic       num_vld_r;
  logic [CHANS-1:0][NUM_W-1:0] num_r;
  logic [POS_W-1:0]            div_r;

  // effective stop count
  always_comb begin
    n_eff = {1'b0, stops_in_use};
    if (n_eff < 4'd2) begin
      n_eff = 4'd2;
    end else if (n_eff > 4'(LIM)) begin
      n_eff = 4'(LIM);
    end
  end

  // first matching pair wins; default is stop 0 with zero gap
  always_comb begin
    logic [POS_W-1:0] p0, p1;
    sel_nxt.gap   = '0;
    sel_nxt.delta = '0;
    sel_nxt.col_a = stop_col(stops[0]);
    sel_nxt.col_b = stop_col(stops[0]);
    for (int i = PAIRS - 1; i >= 0; i--) begin
      p0 = stop_pos(stops[i]);
      p1 = stop_pos(stops[i+1]);
      if ((4'(i + 1) < n_eff) && (t_val >= p0) && (t_val <= p1)) begin
        sel_nxt.gap   = p1 - p0;
        sel_nxt.delta = t_val - p0;
        sel_nxt.col_a = stop_col(stops[i]);
        sel_nxt.col_b = stop_col(stops[i+1]);
      end
    end
  end

  // stage 3: pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else if (advance) begin
      sel_vld_r <= t_vld;
    end
    if (advance) begin
      sel_r <= sel_nxt;
    end
  end

  // stage 4: weight products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_vld_r <= 1'b0;
    end else if (advance) begin
      prd_vld_r <= sel_vld_r;
    end
    if (advance) begin
      for (int c = 0; c < CHANS; c++) begin
        pa_r[c] <= NUM_W'(sel_r.col_a[c] * (sel_r.gap - sel_r.delta));
        pb_r[c] <= NUM_W'(sel_r.col_b[c] * sel_r.delta);
      end
      pgap_r <= sel_r.gap;
      pcol_r <= sel_r.col_a;
    end
  end

  // stage 5: numerator; a zero gap passes the lower color through as n / 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vld_r <= 1'b0;
    end else if (advance) begin
      num_vld_r <= prd_vld_r;
    end
    if (advance) begin
      for (int c = 0; c < CHANS; c++) begin
        num_r[c] <= (pgap_r == '0) ? NUM_W'(pcol_r[c]) : pa_r[c] + pb_r[c];
      end
      div_r <= (pgap_r == '0) ? POS_W'(1) : pgap_r;
    end
  end

  assign num_vld = num_vld_r;
  assign num     = num_r;
  assign divisor = div_r;
  assign sel_dbg = sel_r;

endmodule

// File: sv/lgpc_div.sv
// ---------------------------------------------------------------------------
// lgpc_div
// Restoring divider, one quotient bit per stage, four channels side by side.
// ---------------------------------------------------------------------------
module lgpc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic                         num_vld,
  input  logic [lgpc_pkg::CHANS-1:0][lgpc_pkg::NUM_W-1:0] num,
  input  logic [lgpc_pkg::POS_W-1:0]   divisor,
  output logic                         quo_vld,
  output lgpc_pkg::chan_t              quo
);
  import lgpc_pkg::*;

  logic                         v_s [DIV_BITS+1];
  logic [CHANS-1:0][NUM_W-1:0]  r_s [DIV_BITS+1];
  chan_t                        q_s [DIV_BITS+1];
  logic [POS_W-1:0]             g_s [DIV_BITS+1];

  logic                         v_r [DIV_BITS];
  logic [CHANS-1:0][NUM_W-1:0]  r_r [DIV_BITS];
  chan_t                        q_r [DIV_BITS];
  logic [POS_W-1:0]             g_r [DIV_BITS];

  assign v_s[0] = num_vld;
  assign r_s[0] = num;
  assign q_s[0] = '0;
  assign g_s[0] = divisor;

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
    localparam int K = DIV_BITS - 1 - j;
    logic [NUM_W-1:0]            gs;
    logic [CHANS-1:0][NUM_W-1:0] r_nxt;
    chan_t                       q_nxt;

    // try subtracting the shifted divisor
    always_comb begin
      gs    = NUM_W'(g_s[j]) << K;
      r_nxt = r_s[j];
      q_nxt = q_s[j];
      for (int c = 0; c < CHANS; c++) begin
        if (r_s[j][c] >= gs) begin
          r_nxt[c]    = r_s[j][c] - gs;
          q_nxt[c][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (advance) begin
        v_r[j] <= v_s[j];
      end
      if (advance) begin
        r_r[j] <= r_nxt;
        q_r[j] <= q_nxt;
        g_r[j] <= g_s[j];
      end
    end

    assign v_s[j+1] = v_r[j];
    assign r_s[j+1] = r_r[j];
    assign q_s[j+1] = q_r[j];
    assign g_s[j+1] = g_r[j];
  end

  assign quo_vld = v_s[DIV_BITS];
  assign quo     = q_s[DIV_BITS];

`ifndef NO_ASSERTIONS
  // divisor entering a valid slot is never zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    num_vld |-> divisor != '0)
    else $error("zero divisor entered the divider");

  // final remainder is below the divisor
  a_rem_small: assert property (@(posedge clk) disable iff (!rst_n)
    quo_vld |-> (r_s[DIV_BITS][0] < NUM_W'(g_s[DIV_BITS])) &&
                (r_s[DIV_BITS][1] < NUM_W'(g_s[DIV_BITS])) &&
                (r_s[DIV_BITS][2] < NUM_W'(g_s[DIV_BITS])) &&
                (r_s[DIV_BITS][3] < NUM_W'(g_s[DIV_BITS])))
    else $error("divider remainder not reduced");

  // a stall freezes the last stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(quo) && $stable(quo_vld))
    else $error("divider output moved during stall");
`endif

endmodule

// File: sv/linear_gradient_pixel_color.sv
// ---------------------------------------------------------------------------
// linear_gradient_pixel_color
// Linear gradient color for one pixel offset per request, up to four stops.
// ---------------------------------------------------------------------------
// Takes one pixel request per clock and returns one RGBA result per clock
// while the output is not stalled; a request passes 13 register stages: two
// stages form t, three pick the stop pair and build the weighted sums, and the
// 8-stage restoring divider (one quotient bit per stage) forms the quotient.
// The whole pipeline holds in place while the output is stalled. The user
// must write configuration through the cfg port only while no pixel is in
// flight; the block itself does not enforce this.
module linear_gradient_pixel_color #(
  parameter int MAX_STOPS  = 4,
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] in_tdata,  // offset_x, offset_y
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // red, green, blue, alpha
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lgpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgpc_pkg::STOP_W-1:0]       cfg_data
);
  import lgpc_pkg::*;

  logic signed [COEF_W-1:0] coef_x_r, coef_y_r;
  logic [2:0]               stops_r;
  stop_bank_t               stop_r;
  logic                     advance;
  logic                     t_vld;
  logic [POS_W-1:0]         t_val;
  logic                     num_vld;
  logic [CHANS-1:0][NUM_W-1:0] num;
  logic [POS_W-1:0]         divisor;
  sel_t                     sel_dbg;
  logic                     quo_vld;
  chan_t                    quo;

  // register writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= '0;
      coef_y_r <= '0;
      stops_r  <= 3'd2;
      stop_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_X: coef_x_r  <= cfg_data[COEF_W-1:0];
        REG_COEF_Y: coef_y_r  <= cfg_data[COEF_W-1:0];
        REG_STOPS:  stops_r   <= cfg_data[2:0];
        REG_STOP_0: stop_r[0] <= cfg_data;
        REG_STOP_1: stop_r[1] <= cfg_data;
        REG_STOP_2: stop_r[2] <= cfg_data;
        REG_STOP_3: stop_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output holds an untaken result
  assign advance   = !quo_vld || out_tready;
  assign in_tready = advance;

  lgpc_coord #(.COORD_BITS(COORD_BITS)) u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .in_vld  (in_tvalid),
    .off_x   (in_tdata[COORD_BITS-1:0]),
    .off_y   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .coef_x  (coef_x_r),
    .coef_y  (coef_y_r),
    .t_vld   (t_vld),
    .t_val   (t_val)
  );

  lgpc_stop_sel #(.MAX_STOPS(MAX_STOPS)) u_sel (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .t_vld        (t_vld),
    .t_val        (t_val),
    .stops_in_use (stops_r),
    .stops        (stop_r),
    .num_vld      (num_vld),
    .num          (num),
    .divisor      (divisor),
    .sel_dbg      (sel_dbg)
  );

  lgpc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .num_vld (num_vld),
    .num     (num),
    .divisor (divisor),
    .quo_vld (quo_vld),
    .quo     (quo)
  );

  assign out_tvalid = quo_vld;
  assign out_tdata  = quo;

`ifndef NO_ASSERTIONS
  // selected pair distance never exceeds its gap
  a_dist_le_gap: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> sel_dbg.delta <= sel_dbg.gap)
    else $error("pair distance exceeds gap");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // requests are refused only while a result waits
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused without output stall");
`endif

endmodule

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// Linear gradient pixel color testbench
// Drives pixel offsets and configuration writes into the gradient block and
// checks every RGBA result against a local fixed-point gradient predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import lgpc_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STOP_W-1:0]    cfg_data;

  bit no_idle;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // gradient predictor plus queue of pending colors
  class gradient_scoreboard;
    longint     coef_x, coef_y;
    int         stop_cnt;
    logic [STOP_W-1:0] stops[STOP_REGS];
    rgba_t      pending[$];
    int         errors;

    function void set_reg(cfg_reg_t idx, logic [STOP_W-1:0] v);
      case (idx)
        REG_COEF_X: coef_x = longint'($signed(v[COEF_W-1:0]));
        REG_COEF_Y: coef_y = longint'($signed(v[COEF_W-1:0]));
        REG_STOPS:  stop_cnt = int'(v[2:0]);
        default:    stops[idx - REG_STOP_0] = v;
      endcase
    endfunction

    function void reset_regs();
      coef_x = 0;
      coef_y = 0;
      stop_cnt = 2;
      foreach (stops[k]) stops[k] = '0;
    endfunction

    function void note_pixel(logic [23:0] d);
      longint s, t, p0, p1, g, dd, a, b;
      int n;
      bit hit;
      logic [7:0] ch[4];
      rgba_t r;
      s = longint'(d[11:0]) * coef_x + longint'(d[23:12]) * coef_y;
      if (s <= 0) t = 0;
      else t = (s >> 8) > 65536 ? 65536 : (s >> 8);
      n = stop_cnt < 2 ? 2 : (stop_cnt > STOP_REGS ? STOP_REGS : stop_cnt);
      for (int c = 0; c < 4; c++) ch[c] = stops[0][31 - 8*c -: 8];
      hit = 0;
      for (int i = 0; i + 1 < n && !hit; i++) begin
        p0 = stops[i][48:32];
        p1 = stops[i+1][48:32];
        if (t >= p0 && t <= p1) begin
          hit = 1;
          g = p1 - p0;
          dd = t - p0;
          for (int c = 0; c < 4; c++) begin
            a = stops[i][31 - 8*c -: 8];
            b = stops[i+1][31 - 8*c -: 8];
            ch[c] = (g == 0) ? a[7:0] : 8'((a * (g - dd) + b * dd) / g);
          end
        end
      end
      r.red = ch[0]; r.green = ch[1]; r.blue = ch[2]; r.alpha = ch[3];
      pending.push_back(r);
    endfunction

    function void check_pixel(logic [31:0] d);
      rgba_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[7:0] !== e.red) begin
        $error("red exp %0d got %0d", e.red, d[7:0]); errors++;
      end
      if (d[15:8] !== e.green) begin
        $error("green exp %0d got %0d", e.green, d[15:8]); errors++;
      end
      if (d[23:16] !== e.blue) begin
        $error("blue exp %0d got %0d", e.blue, d[23:16]); errors++;
      end
      if (d[31:24] !== e.alpha) begin
        $error("alpha exp %0d got %0d", e.alpha, d[31:24]); errors++;
      end
    endfunction
  endclass

  gradient_scoreboard sb;

  linear_gradient_pixel_color dut (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // result side: random stalls, check on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_pixel(out_tdata);
      out_tready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  // one register write; leaves a gap before the next request
  task automatic write_reg(cfg_reg_t idx, logic [STOP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [11:0] ox, logic [11:0] oy, bit may_idle);
    while (may_idle && !no_idle && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {oy, ox};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel({oy, ox});
  endtask

  // wait until the pipeline is empty, then settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [STOP_W-1:0] stop_word(int pos, logic [31:0] rgba);
    return {17'(pos), rgba};
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0: return COEF_W'(16777216);
      1: return COEF_W'(-16777216);
      2: return COEF_W'($urandom_range(16777216, 0) >> $urandom_range(16));
      3: return COEF_W'(-int'($urandom_range(16777216) >> $urandom_range(16)));
      default: return COEF_W'($urandom_range(8192));
    endcase
  endfunction

  // random setup: positions mostly sorted and within [0, 1]
  task automatic random_setup();
    int p[4];
    write_reg(REG_COEF_X, STOP_W'(rand_coef()));
    write_reg(REG_COEF_Y, STOP_W'(rand_coef()));
    write_reg(REG_STOPS, STOP_W'($urandom_range(7)));
    for (int k = 0; k < 4; k++) p[k] = $urandom_range(65536);
    p.sort();
    if ($urandom_range(3) == 0) p[1] = p[2];       // zero-width pair
    if ($urandom_range(5) == 0) p[0] = $urandom_range(131071);  // unsorted
    if ($urandom_range(5) == 0) p[3] = $urandom_range(131071, 65537);
    for (int k = 0; k < 4; k++)
      write_reg(cfg_reg_t'(REG_STOP_0 + k), stop_word(p[k], $urandom()));
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COEF_X;
    cfg_data = '0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, then extremes and stop cases
    send_pixel(12'd0, 12'd0, 1'b0);
    send_pixel(12'hFFF, 12'hFFF, 1'b0);
    drain();
    write_reg(REG_COEF_X, STOP_W'(COEF_W'(16777216 / 4096)));
    write_reg(REG_COEF_Y, STOP_W'(COEF_W'(-16777216)));
    write_reg(REG_STOPS, STOP_W'(3'd4));
    write_reg(REG_STOP_0, stop_word(0,     32'hFF00_00FF));
    write_reg(REG_STOP_1, stop_word(20000, 32'h00FF_0080));
    write_reg(REG_STOP_2, stop_word(20000, 32'h1234_5678));
    write_reg(REG_STOP_3, stop_word(65536, 32'h00FF_FF00));
    send_pixel(12'hFFF, 12'd0, 1'b0);
    send_pixel(12'd0, 12'd1, 1'b0);
    send_pixel(12'd1250, 12'd0, 1'b0);
    send_pixel(12'd2048, 12'd0, 1'b0);
    send_pixel(12'd4095, 12'd0, 1'b0);
    send_pixel(12'h555, 12'd0, 1'b0);
    send_pixel(12'hAAA, 12'd0, 1'b0);
    drain();
    // one pixel inside the pair, one below it; stop count out of range
    write_reg(REG_COEF_X, STOP_W'(COEF_W'(16777216)));
    write_reg(REG_STOPS, STOP_W'(3'd0));
    write_reg(REG_STOP_0, stop_word(100, 32'hA5A5_5A5A));
    write_reg(REG_STOP_1, stop_word(131071, 32'h5A5A_A5A5));
    send_pixel(12'd1, 12'd0, 1'b0);
    send_pixel(12'd0, 12'd0, 1'b0);
    drain();
    write_reg(REG_STOPS, STOP_W'(3'd7));
    write_reg(REG_STOP_1, stop_word(200, 32'h0));
    send_pixel(12'd1, 12'd0, 1'b0);
    send_pixel(12'hFFF, 12'hFFF, 1'b0);
    drain();

    // random phases
    for (int ph = 0; ph < 26; ph++) begin
      random_setup();
      no_idle = (ph == 5);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(3) == 0)
          send_pixel(12'($urandom()), 12'($urandom()), 1'b1);
        else
          send_pixel(12'($urandom_range(255) << $urandom_range(4)),
                     12'($urandom_range(255) << $urandom_range(4)), 1'b1);
        if (ph == 10 && k == 25) begin
          // hold off until every pending color has come back
          in_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    no_idle = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
